FILE: hdl/gbpb_pkg.sv
// Shared types and constants of the Goertzel bin power bank.
package gbpb_pkg;

  localparam int COEFF_W      = 17;   // signed Q2.14 coefficient
  localparam int WL_W         = 13;   // window length register
  localparam int Q_W          = 48;   // delay state q1, q2
  localparam int SAMPLE_MAX_W = 24;   // widest sample the command queue carries
  localparam int POWER_W      = 63;
  localparam int BIN_IDX_W    = 2;
  localparam int COEFF_REGS   = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 17;

  localparam int CMD_DEPTH    = 2;
  localparam int LIMB_W       = 24;   // operand slice of the shared multiplier
  localparam int ACC_W        = 112;  // holds the largest product, |q1*c|*|q2| < 2^111
  localparam int SUM_W        = 100;  // signed power before clamping, |x| < 2^97

  localparam logic [WL_W-1:0] WL_RESET = 13'd205;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_0       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_1       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_2       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF_3       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd4;

  typedef logic signed [COEFF_W-1:0] coeff_t;

  // One classified sample on its way from the front to the back.
  typedef struct packed {
    logic signed [SAMPLE_MAX_W-1:0] sample;
    logic                           last;
  } cmd_t;

  // One bin result.
  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin_index;
    logic [POWER_W-1:0]   power;
    logic                 last_bin;
  } res_t;

endpackage

FILE: hdl/gbpb_front.sv
// Front end: sample intake, window counting and the command queue.
module gbpb_front #(
  parameter int MAX_WINDOW  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_i,
  output logic                            full_o,
  input  logic [gbpb_pkg::WL_W-1:0]       window_length_i,
  output logic                            cmd_valid_o,
  output gbpb_pkg::cmd_t                  cmd_o,
  input  logic                            cmd_pop_i
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int LEN_W = (CNT_W > gbpb_pkg::WL_W) ? CNT_W : gbpb_pkg::WL_W;
  localparam int PTR_W = $clog2(gbpb_pkg::CMD_DEPTH);
  localparam int QC_W  = $clog2(gbpb_pkg::CMD_DEPTH + 1);

  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [LEN_W-1:0]     wl_ext, len_eff, cnt_inc;
  logic                 is_last, wr_en;
  gbpb_pkg::cmd_t       mem_q [gbpb_pkg::CMD_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0]      qcnt_q;

  // Zero length acts as one, overlong windows clamp to MAX_WINDOW.
  always_comb begin
    wl_ext = LEN_W'(window_length_i);
    if (wl_ext == '0) begin
      len_eff = LEN_W'(1);
    end else if (wl_ext > LEN_W'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = wl_ext;
    end
    cnt_inc = LEN_W'(cnt_q) + LEN_W'(1);
    is_last = (cnt_inc >= len_eff);
    cnt_d   = is_last ? '0 : cnt_inc[CNT_W-1:0];
  end

  assign full_o      = (qcnt_q == QC_W'(gbpb_pkg::CMD_DEPTH));
  assign wr_en       = push_i && !full_o;
  assign cmd_valid_o = (qcnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      qcnt_q   <= '0;
    end else begin
      if (wr_en) begin
        cnt_q    <= cnt_d;
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (cmd_pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      qcnt_q <= qcnt_q + QC_W'(wr_en) - QC_W'(cmd_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q].sample <= gbpb_pkg::SAMPLE_MAX_W'(sample_i);
      mem_q[wr_ptr_q].last   <= is_last;
    end
  end

  a_cnt_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(cnt_q) < LEN_W'(MAX_WINDOW))
    else $error("sample count left the window");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> cmd_valid_o)
    else $error("command popped from empty queue");

endmodule

FILE: hdl/gbpb_res_fifo.sv
// Result queue between the back end and the output channel.
module gbpb_res_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  gbpb_pkg::res_t wdata_i,
  output logic           full_o,
  input  logic           rd_i,
  output gbpb_pkg::res_t rdata_o,
  output logic           empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gbpb_pkg::res_t    mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              wr_en, rd_en;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = wr_i && !full_o;
  assign rd_en   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(wr_en) - CNT_W'(rd_en);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !wr_i)
    else $error("result written into a full queue");

endmodule

FILE: hdl/gbpb_back.sv
// Back end: per-bin Goertzel recurrence and bin power on one shared multiplier.
module gbpb_back #(
  parameter int NUM_BINS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gbpb_pkg::coeff_t    coeff_i [gbpb_pkg::COEFF_REGS],
  input  logic                cmd_valid_i,
  input  gbpb_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                res_wr_o,
  output gbpb_pkg::res_t      res_o,
  input  logic                res_full_i
);

  localparam int Q_W    = gbpb_pkg::Q_W;
  localparam int LW     = gbpb_pkg::LIMB_W;
  localparam int ACC_W  = gbpb_pkg::ACC_W;
  localparam int SUM_W  = gbpb_pkg::SUM_W;
  localparam int CW     = gbpb_pkg::COEFF_W;
  localparam int OPA_W  = 3 * LW;
  localparam int OPB_W  = 2 * LW;
  localparam int REC_W  = Q_W + 18;
  localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SETUP, ST_MUL, ST_DRAIN, ST_POST, ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    JOB_REC, JOB_SQ1, JOB_SQ2, JOB_T, JOB_X
  } job_e;

  function automatic logic [Q_W-1:0] mag_q(input logic signed [Q_W-1:0] v);
    return v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
  endfunction

  function automatic logic [CW-1:0] mag_c(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  state_e                     state_q;
  job_e                       job_q;
  logic [BIN_W-1:0]           bin_q;
  logic                       last_q;
  logic [1:0]                 i_q, na_q, na_d;
  logic                       j_q;
  logic                       pv_q;
  logic signed [Q_W-1:0]      d1_q [NUM_BINS];
  logic signed [Q_W-1:0]      d2_q [NUM_BINS];

  logic signed [gbpb_pkg::SAMPLE_MAX_W-1:0] x_q;
  logic [2*LW-1:0]            prod_q;
  logic [1:0]                 sh_q;
  logic [ACC_W-1:0]           acc_q, acc_add;
  logic [OPA_W-1:0]           op_a_q, op_a_d;
  logic [OPB_W-1:0]           op_b_q, op_b_d;
  logic [63:0]                t_q;
  logic signed [SUM_W-1:0]    sum_q;

  logic signed [Q_W-1:0]      cur_q1, cur_q2;
  logic signed [CW-1:0]       cur_c;
  logic [LW-1:0]              limb_a, limb_b;
  logic                       bin_last, issue_done;

  logic                       neg_r, neg_x;
  logic signed [64:0]         pm, p_sh;
  logic signed [REC_W-1:0]    q0w;
  logic [REC_W-Q_W:0]         q0_hi;
  logic signed [Q_W-1:0]      q0;
  logic signed [ACC_W:0]      xs, x_sh;
  logic [gbpb_pkg::POWER_W-1:0] power;

  always_comb begin
    cur_c = '0;
    for (int k = 0; k < gbpb_pkg::COEFF_REGS; k++) begin
      if (int'(bin_q) == k) begin
        cur_c = coeff_i[k];
      end
    end
  end

  assign cur_q1   = d1_q[bin_q];
  assign cur_q2   = d2_q[bin_q];
  assign bin_last = (bin_q == BIN_W'(NUM_BINS - 1));

  // Operand setup for the next multiply job.
  always_comb begin
    op_a_d = '0;
    op_b_d = mag_q(cur_q1);
    na_d   = 2'd1;
    case (job_q)
      JOB_REC, JOB_T: begin
        op_a_d = OPA_W'(mag_c(cur_c));
      end
      JOB_SQ1: begin
        op_a_d = OPA_W'(mag_q(cur_q1));
        na_d   = 2'd2;
      end
      JOB_SQ2: begin
        op_a_d = OPA_W'(mag_q(cur_q2));
        op_b_d = mag_q(cur_q2);
        na_d   = 2'd2;
      end
      JOB_X: begin
        op_a_d = OPA_W'(t_q);
        op_b_d = mag_q(cur_q2);
        na_d   = 2'd3;
      end
      default: begin
        op_a_d = '0;
      end
    endcase
  end

  assign limb_a     = op_a_q[i_q * LW +: LW];
  assign limb_b     = op_b_q[j_q * LW +: LW];
  assign issue_done = j_q && (i_q == na_q - 2'd1);

  // Place the registered partial product at its limb offset.
  always_comb begin
    case (sh_q)
      2'd0:    acc_add = ACC_W'(prod_q);
      2'd1:    acc_add = ACC_W'(prod_q) << LW;
      2'd2:    acc_add = ACC_W'(prod_q) << (2 * LW);
      default: acc_add = ACC_W'(prod_q) << (3 * LW);
    endcase
  end

  // Recurrence: q0 = floor(c*q1 / 2^14) - q2 + x, saturated to 48 bits.
  always_comb begin
    neg_r = cur_c[CW-1] ^ cur_q1[Q_W-1];
    pm    = neg_r ? -$signed({1'b0, acc_q[63:0]}) : $signed({1'b0, acc_q[63:0]});
    p_sh  = pm >>> 14;
    q0w   = REC_W'(p_sh) - REC_W'(cur_q2) + REC_W'(x_q);
    q0_hi = q0w[REC_W-1:Q_W-1];
    if ((&q0_hi) || !(|q0_hi)) begin
      q0 = q0w[Q_W-1:0];
    end else if (q0w[REC_W-1]) begin
      q0 = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      q0 = {1'b0, {(Q_W-1){1'b1}}};
    end
  end

  // Cross term floor(q1*q2*c / 2^14) and the clamped power.
  always_comb begin
    neg_x = cur_q1[Q_W-1] ^ cur_q2[Q_W-1] ^ cur_c[CW-1];
    xs    = neg_x ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
    x_sh  = xs >>> 14;
    if (sum_q[SUM_W-1]) begin
      power = '0;
    end else if (|sum_q[SUM_W-2:gbpb_pkg::POWER_W]) begin
      power = '1;
    end else begin
      power = sum_q[gbpb_pkg::POWER_W-1:0];
    end
  end

  assign cmd_pop_o         = (state_q == ST_IDLE) && cmd_valid_i;
  assign res_wr_o          = (state_q == ST_EMIT) && !res_full_i;
  assign res_o.bin_index   = gbpb_pkg::BIN_IDX_W'(bin_q);
  assign res_o.power       = power;
  assign res_o.last_bin    = bin_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= JOB_REC;
      bin_q   <= '0;
      last_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= 1'b0;
      na_q    <= 2'd1;
      pv_q    <= 1'b0;
      for (int k = 0; k < NUM_BINS; k++) begin
        d1_q[k] <= '0;
        d2_q[k] <= '0;
      end
    end else begin
      pv_q <= (state_q == ST_MUL);
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            last_q  <= cmd_i.last;
            bin_q   <= '0;
            job_q   <= JOB_REC;
            state_q <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          na_q    <= na_d;
          i_q     <= '0;
          j_q     <= 1'b0;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          // Walk the limb pairs, B limb fastest.
          if (issue_done) begin
            state_q <= ST_DRAIN;
          end else if (j_q) begin
            j_q <= 1'b0;
            i_q <= i_q + 2'd1;
          end else begin
            j_q <= 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_POST;
        end
        ST_POST: begin
          unique case (job_q)
            JOB_REC: begin
              d2_q[bin_q] <= cur_q1;
              d1_q[bin_q] <= q0;
              if (last_q) begin
                job_q   <= JOB_SQ1;
                state_q <= ST_SETUP;
              end else if (bin_last) begin
                state_q <= ST_IDLE;
              end else begin
                bin_q   <= bin_q + BIN_W'(1);
                state_q <= ST_SETUP;
              end
            end
            JOB_SQ1: begin
              job_q   <= JOB_SQ2;
              state_q <= ST_SETUP;
            end
            JOB_SQ2: begin
              job_q   <= JOB_T;
              state_q <= ST_SETUP;
            end
            JOB_T: begin
              job_q   <= JOB_X;
              state_q <= ST_SETUP;
            end
            JOB_X: begin
              state_q <= ST_EMIT;
            end
            default: begin
              state_q <= ST_IDLE;
            end
          endcase
        end
        ST_EMIT: begin
          // Hold until the result queue has room, then clear the bin.
          if (!res_full_i) begin
            d1_q[bin_q] <= '0;
            d2_q[bin_q] <= '0;
            job_q       <= JOB_REC;
            if (bin_last) begin
              state_q <= ST_IDLE;
            end else begin
              bin_q   <= bin_q + BIN_W'(1);
              state_q <= ST_SETUP;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= (2 * LW)'(limb_a) * (2 * LW)'(limb_b);
    sh_q   <= i_q + 2'(j_q);
    if (cmd_pop_o) begin
      x_q <= cmd_i.sample;
    end
    if (state_q == ST_SETUP) begin
      acc_q  <= '0;
      op_a_q <= op_a_d;
      op_b_q <= op_b_d;
    end else if (pv_q) begin
      acc_q <= acc_q + acc_add;
    end
    if (state_q == ST_POST) begin
      case (job_q)
        JOB_SQ1: sum_q <= $signed(acc_q[SUM_W-1:0]);
        JOB_SQ2: sum_q <= sum_q + $signed(acc_q[SUM_W-1:0]);
        JOB_T:   t_q   <= acc_q[63:0];
        JOB_X:   sum_q <= sum_q - $signed(x_sh[SUM_W-1:0]);
        default: t_q   <= t_q;
      endcase
    end
  end

  a_pv_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> ($past(state_q) == ST_MUL))
    else $error("partial product without an issue cycle");

  a_drain_has_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> pv_q)
    else $error("drain cycle without the final partial product");

endmodule

FILE: hdl/goertzel_bin_power_bank_top.sv
// Top level of the Goertzel bin power bank: configuration registers and channel wiring.
//
// Usage. Samples enter through a queue-like port: a sample on sample_i is
// transferred at a rising edge with push high and full low. Bin results leave
// through a second queue-like port: while empty is low the oldest result sits
// on bin_index_o, power_o and last_bin_o, and it is transferred at a rising
// edge with pop high. Registers are written through cfg_we_i/cfg_idx_i/
// cfg_data_i: indexes 0 to 3 are the Q2.14 bin coefficients,
// index 4 the window length; other indexes are dropped.
// Arithmetic. One shared 24x24 multiplier does all the math. The sample that
// closes a window costs the back end more than an ordinary sample, the extra
// going to the squared terms and the cross term of each bin's power, done
// limb by limb. The back end finishes one sample before it takes the next.
// A two-entry command queue lets the front take samples while the back works.
// Results. Those of a window leave in bin order once its last sample is in.
// Reset. Clears delay state, sample count, both queues; coefficients read 0
// and the window length 205. A stalled receiver fills the result queue
// (NUM_BINS deep); the back end then holds, the command queue fills and full
// rises, so nothing is dropped.
module goertzel_bin_power_bank_top #(
  parameter int NUM_BINS    = 4,
  parameter int MAX_WINDOW  = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  output logic                                 full,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [gbpb_pkg::BIN_IDX_W-1:0]       bin_index_o,
  output logic [gbpb_pkg::POWER_W-1:0]         power_o,
  output logic                                 last_bin_o,
  input  logic                                 cfg_we_i,
  input  logic [gbpb_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gbpb_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  gbpb_pkg::coeff_t             coeff_q [gbpb_pkg::COEFF_REGS];
  logic [gbpb_pkg::WL_W-1:0]    wl_q;

  logic                         cmd_valid, cmd_pop;
  gbpb_pkg::cmd_t               cmd;
  logic                         res_wr, res_full;
  gbpb_pkg::res_t               res_in, res_out;

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < gbpb_pkg::COEFF_REGS; k++) begin
        coeff_q[k] <= '0;
      end
      wl_q <= gbpb_pkg::WL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i) inside
        gbpb_pkg::CFG_COEFF_0, gbpb_pkg::CFG_COEFF_1,
        gbpb_pkg::CFG_COEFF_2, gbpb_pkg::CFG_COEFF_3: begin
          coeff_q[cfg_idx_i[1:0]] <= $signed(cfg_data_i[gbpb_pkg::COEFF_W-1:0]);
        end
        gbpb_pkg::CFG_WINDOW_LENGTH: begin
          wl_q <= cfg_data_i[gbpb_pkg::WL_W-1:0];
        end
        default: begin
          // Drop writes beyond the register list.
          wl_q <= wl_q;
        end
      endcase
    end
  end

  // Front: count samples and tag the one that closes a window.
  gbpb_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .sample_i        (sample_i),
    .full_o          (full),
    .window_length_i (wl_q),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  // Back: advance every bin, and on a window end compute and emit the powers.
  gbpb_back #(
    .NUM_BINS (NUM_BINS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coeff_i     (coeff_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_wr_o    (res_wr),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  // Result queue decouples the back end from a stalled receiver.
  gbpb_res_fifo #(
    .DEPTH (NUM_BINS)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .wdata_i (res_in),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign bin_index_o = res_out.bin_index;
  assign power_o     = res_out.power;
  assign last_bin_o  = res_out.last_bin;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Goertzel bin power bank: queue driver, result monitor.
module tb;

  localparam int NUM_BINS      = 4;
  localparam int MAX_WINDOW    = 4096;
  localparam int SAMPLE_BITS   = 16;
  // The back end may still chew on up to three samples that close no window
  // (two in the command queue, one in flight).
  localparam int SETTLE_CYCLES = 150;
  localparam int RANDOM_ITEMS  = 100;
  localparam int TAIL_ITEMS    = 16;
  localparam int REPORT_LIMIT  = 10;

  // Delay state saturates to the signed 48-bit range.
  localparam longint Q_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint Q_LO = -Q_HI - 64'sd1;

  // Corner coefficient patterns: the full 17-bit reach and +/-2.0 in Q2.14.
  localparam gbpb_pkg::coeff_t C_TOP       = 17'h0FFFF;
  localparam gbpb_pkg::coeff_t C_BOTTOM    = 17'h10000;
  localparam gbpb_pkg::coeff_t C_PLUS_TWO  = 17'h08000;
  localparam gbpb_pkg::coeff_t C_MINUS_TWO = 17'h18000;

  logic                                  clk_i      = 1'b0;
  logic                                  rst_ni     = 1'b0;
  logic                                  push       = 1'b0;
  logic signed [SAMPLE_BITS-1:0]         sample_i   = '0;
  logic                                  full;
  logic                                  empty;
  logic                                  pop        = 1'b0;
  logic [gbpb_pkg::BIN_IDX_W-1:0]        bin_index_o;
  logic [gbpb_pkg::POWER_W-1:0]          power_o;
  logic                                  last_bin_o;
  logic                                  cfg_we_i   = 1'b0;
  logic [gbpb_pkg::CFG_IDX_W-1:0]        cfg_idx_i  = '0;
  logic [gbpb_pkg::CFG_DATA_W-1:0]       cfg_data_i = '0;

  goertzel_bin_power_bank_top #(
    .NUM_BINS    (NUM_BINS),
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .sample_i    (sample_i),
    .full        (full),
    .empty       (empty),
    .pop         (pop),
    .bin_index_o (bin_index_o),
    .power_o     (power_o),
    .last_bin_o  (last_bin_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Goertzel predictor: own copy of the registers and the per-bin delay line.
  // ---------------------------------------------------------------------------
  gbpb_pkg::coeff_t          bin_coeff [NUM_BINS];
  logic [gbpb_pkg::WL_W-1:0] win_len;
  longint                    q_one [NUM_BINS];
  longint                    q_two [NUM_BINS];
  int                        in_window;
  gbpb_pkg::res_t            power_due [$];   // bin results still owed by the block

  // power = q1^2 + q2^2 - floor(q1*q2*c / 2^14), clamped at zero, saturated at 2^63-1.
  function automatic logic [gbpb_pkg::POWER_W-1:0] bin_power(input longint q1,
                                                             input longint q2,
                                                             input gbpb_pkg::coeff_t c);
    logic signed [127:0] a;
    logic signed [127:0] b;
    logic signed [127:0] k;
    logic signed [127:0] acc;
    a = q1;
    b = q2;
    k = c;
    acc = a * a + b * b - ((a * b * k) >>> 14);
    if (acc < 0) return '0;
    if (acc > 128'sh7FFF_FFFF_FFFF_FFFF) return '1;
    return acc[gbpb_pkg::POWER_W-1:0];
  endfunction

  // Advance every bin by one sample; close the window when the count is reached.
  function automatic void advance_goertzel(input logic signed [SAMPLE_BITS-1:0] x);
    logic signed [127:0] acc;
    longint              xs;
    int                  len;
    gbpb_pkg::res_t      r;
    xs  = x;
    len = win_len;
    // A zero length acts as one, anything above the window store as its size.
    if (len == 0) len = 1;
    if (len > MAX_WINDOW) len = MAX_WINDOW;
    for (int i = 0; i < NUM_BINS; i++) begin
      acc = bin_coeff[i] * q_one[i];
      acc = (acc >>> 14) - q_two[i] + xs;
      q_two[i] = q_one[i];
      if (acc > Q_HI) q_one[i] = Q_HI;
      else if (acc < Q_LO) q_one[i] = Q_LO;
      else q_one[i] = acc[63:0];
    end
    in_window++;
    // A length lowered mid-window ends it on the first sample at or past it.
    if (in_window < len) return;
    for (int i = 0; i < NUM_BINS; i++) begin
      r.bin_index = gbpb_pkg::BIN_IDX_W'(i);
      r.power     = bin_power(q_one[i], q_two[i], bin_coeff[i]);
      r.last_bin  = (i == NUM_BINS - 1);
      power_due.push_back(r);
      q_one[i] = 0;
      q_two[i] = 0;
    end
    in_window = 0;
  endfunction

  // Draw an idle count per transfer; now and then run a stretch with no idling.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = int'($urandom_range(10, 40));
      return 0;
    end
    return int'($urandom_range(0, 10));
  endfunction

  // ---------------------------------------------------------------------------
  // Sample driver: pull from the pending queue, hold push until transfer.
  // ---------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] pending [$];
  int items_queued = 0;
  int items_taken  = 0;
  int push_wait    = 0;
  int push_calm    = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        // Transfer: predict first, then count it so the sequencer sees both.
        advance_goertzel(sample_i);
        items_taken++;
        push_wait = draw_wait(push_calm);
        // Keep push high for back-to-back transfers; drop it otherwise.
        if (push_wait == 0 && pending.size() > 0) begin
          sample_i <= pending.pop_front();
        end else begin
          push <= 1'b0;
        end
      end else if (!push) begin
        if (push_wait > 0) push_wait--;
        if (push_wait == 0 && pending.size() > 0) begin
          push     <= 1'b1;
          sample_i <= pending.pop_front();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: stall pop at random, check each transfer against the oldest
  // owed bin result.
  // ---------------------------------------------------------------------------
  int             bad_results = 0;
  int             pop_wait    = 0;
  int             pop_calm    = 0;
  gbpb_pkg::res_t due_res;

  task automatic flag_result(input string what);
    bad_results++;
    if (bad_results <= REPORT_LIMIT) $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (power_due.size() == 0) begin
          flag_result($sformatf("unexpected result: bin %0d power %0d last %0b",
                                bin_index_o, power_o, last_bin_o));
        end else begin
          due_res = power_due.pop_front();
          if (bin_index_o !== due_res.bin_index || power_o !== due_res.power ||
              last_bin_o !== due_res.last_bin) begin
            flag_result($sformatf(
              "mismatch: expected bin %0d power %0d last %0b, got bin %0d power %0d last %0b",
              due_res.bin_index, due_res.power, due_res.last_bin,
              bin_index_o, power_o, last_bin_o));
          end
        end
        pop_wait = draw_wait(pop_calm);
        if (pop_wait != 0) pop <= 1'b0;
      end else if (!pop) begin
        if (pop_wait > 0) pop_wait--;
        if (pop_wait == 0) pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers.
  // ---------------------------------------------------------------------------

  // Write one register at the next edge and mirror it in the predictor.
  // The caller drops cfg_we_i after the last write of a batch.
  task automatic write_reg(input logic [gbpb_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [gbpb_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx <= gbpb_pkg::CFG_COEFF_3) bin_coeff[idx[1:0]] = data;
    else if (idx == gbpb_pkg::CFG_WINDOW_LENGTH) win_len = data[gbpb_pkg::WL_W-1:0];
  endtask

  function automatic void feed(input logic signed [SAMPLE_BITS-1:0] s);
    pending.push_back(s);
    items_queued++;
  endfunction

  // Wait for every queued sample to transfer and every owed result to arrive,
  // then let the back end finish samples that close no window.
  task automatic settle();
    while (items_taken != items_queued) @(posedge clk_i);
    while (power_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] draw_sample();
    case ($urandom_range(0, 5))
      4: begin
        case ($urandom_range(0, 4))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      5: return SAMPLE_BITS'(int'($urandom_range(0, 200)) - 100);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [gbpb_pkg::CFG_DATA_W-1:0] draw_coeff();
    case ($urandom_range(0, 5))
      0, 1: return gbpb_pkg::CFG_DATA_W'($urandom());
      2: begin
        case ($urandom_range(0, 4))
          0: return C_TOP;
          1: return C_BOTTOM;
          2: return C_PLUS_TWO;
          3: return C_MINUS_TWO;
          default: return '0;
        endcase
      end
      default: return gbpb_pkg::CFG_DATA_W'(int'($urandom_range(0, 65536)) - 32768);
    endcase
  endfunction

  // Mostly short windows so results come often; the bits above the length
  // field are junk the block must drop.
  function automatic logic [gbpb_pkg::CFG_DATA_W-1:0] draw_length();
    logic [gbpb_pkg::CFG_DATA_W-1:0] d;
    d = gbpb_pkg::CFG_DATA_W'($urandom());
    case ($urandom_range(0, 9))
      0: d[gbpb_pkg::WL_W-1:0] = '0;
      1: d[gbpb_pkg::WL_W-1:0] = gbpb_pkg::WL_W'($urandom_range(13, 64));
      default: d[gbpb_pkg::WL_W-1:0] = gbpb_pkg::WL_W'($urandom_range(1, 12));
    endcase
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int random_fed;
    int burst;
    for (int i = 0; i < NUM_BINS; i++) begin
      bin_coeff[i] = '0;
      q_one[i]     = 0;
      q_two[i]     = 0;
    end
    win_len    = gbpb_pkg::WL_RESET;
    in_window  = 0;
    random_fed = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Run one full window on the reset registers: zero coefficients, 205 samples.
    for (int i = 0; i < gbpb_pkg::WL_RESET; i++) feed(draw_sample());
    settle();

    // Corner coefficients with a zero window length: every sample closes a window.
    write_reg(gbpb_pkg::CFG_COEFF_0, C_PLUS_TWO);
    write_reg(gbpb_pkg::CFG_COEFF_1, C_MINUS_TWO);
    write_reg(gbpb_pkg::CFG_COEFF_2, C_TOP);
    write_reg(gbpb_pkg::CFG_COEFF_3, C_BOTTOM);
    write_reg(gbpb_pkg::CFG_WINDOW_LENGTH, '0);
    cfg_we_i <= 1'b0;
    feed(16'h7FFF);
    feed(16'h8000);
    feed(16'h0000);
    feed(16'h0001);
    feed(16'hFFFF);
    settle();

    write_reg(gbpb_pkg::CFG_WINDOW_LENGTH, gbpb_pkg::CFG_DATA_W'(1));
    cfg_we_i <= 1'b0;
    feed(16'h5555);
    feed(16'hAAAA);
    settle();

    // Drive the delay line into saturation: near +4.0 grows it positive, near
    // -4.0 grows it with alternating sign. Keep the window open at full length.
    write_reg(gbpb_pkg::CFG_COEFF_0, C_TOP);
    write_reg(gbpb_pkg::CFG_COEFF_1, C_BOTTOM);
    write_reg(gbpb_pkg::CFG_COEFF_2, C_PLUS_TWO);
    write_reg(gbpb_pkg::CFG_COEFF_3, '0);
    write_reg(gbpb_pkg::CFG_WINDOW_LENGTH, gbpb_pkg::CFG_DATA_W'(MAX_WINDOW));
    cfg_we_i <= 1'b0;
    for (int i = 0; i < 20; i++) feed(16'h7FFF);
    settle();

    // Shorten the window mid-way so the next sample closes it. Bin 0 keeps
    // its coefficient and clamps to zero; bin 1 drops to zero and saturates.
    write_reg(gbpb_pkg::CFG_COEFF_1, '0);
    write_reg(gbpb_pkg::CFG_WINDOW_LENGTH, gbpb_pkg::CFG_DATA_W'(5));
    cfg_we_i <= 1'b0;
    feed(16'h8000);
    settle();

    // Random phases: fresh registers (some left as they were), then a burst of
    // samples that may end mid-window.
    while (random_fed < RANDOM_ITEMS) begin
      for (int r = 0; r < gbpb_pkg::COEFF_REGS; r++) begin
        if ($urandom_range(0, 1) == 1) begin
          write_reg(gbpb_pkg::CFG_COEFF_0 + gbpb_pkg::CFG_IDX_W'(r), draw_coeff());
        end
      end
      if ($urandom_range(0, 2) != 0) write_reg(gbpb_pkg::CFG_WINDOW_LENGTH, draw_length());
      // Hit the unused register indexes now and then; the block must drop them.
      if ($urandom_range(0, 5) == 0) begin
        write_reg(gbpb_pkg::CFG_IDX_W'($urandom_range(gbpb_pkg::CFG_WINDOW_LENGTH + 1,
                                                      (1 << gbpb_pkg::CFG_IDX_W) - 1)),
                  gbpb_pkg::CFG_DATA_W'($urandom()));
      end
      cfg_we_i <= 1'b0;
      burst = int'($urandom_range(1, 40));
      for (int i = 0; i < burst; i++) feed(draw_sample());
      random_fed += burst;
      settle();
    end

    // Overlong length: all ones in the register acts as the full 4096, so a
    // short burst must not close the open window.
    for (int r = 0; r < gbpb_pkg::COEFF_REGS; r++) begin
      write_reg(gbpb_pkg::CFG_COEFF_0 + gbpb_pkg::CFG_IDX_W'(r),
                gbpb_pkg::CFG_DATA_W'(int'($urandom_range(0, 65536)) - 32768));
    end
    write_reg(gbpb_pkg::CFG_WINDOW_LENGTH, '1);
    cfg_we_i <= 1'b0;
    for (int i = 0; i < TAIL_ITEMS; i++) feed(draw_sample());
    settle();

    if (bad_results == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/gbpb_pkg.sv
hdl/gbpb_front.sv
hdl/gbpb_res_fifo.sv
hdl/gbpb_back.sv
hdl/goertzel_bin_power_bank_top.sv
verif/tb.sv
